// ----- rtl/core/lsfb_pkg.sv -----
package lsfb_pkg;

	localparam int CH_W   = 7;
	localparam int ROW_W  = 3 * CH_W;
	localparam int PROD_W = 2 * CH_W;
	localparam int IDX_W  = 8;

	localparam logic [1:0] OP_SET     = 2'd0;
	localparam logic [1:0] OP_GET     = 2'd1;
	localparam logic [1:0] OP_FADE    = 2'd2;
	localparam logic [1:0] OP_REFRESH = 2'd3;

	// Reciprocal division: q0 = (p * floor(2^DIV_SHIFT / d)) >> DIV_SHIFT, then one fix-up.
	localparam int DIV_SHIFT  = 21;
	localparam int RECIP_W    = DIV_SHIFT + 1;
	localparam int FADE_DIV   = 100;
	localparam int FADE_RECIP = (1 << DIV_SHIFT) / FADE_DIV;

	typedef enum logic [2:0] {
		K_SET,
		K_GET,
		K_FADE,
		K_REFRESH,
		K_REJECT,
		K_HEAD,
		K_BYTE,
		K_TAIL
	} kind_t;

	typedef enum logic [1:0] {
		BS_IDLE,
		BS_ISSUE,
		BS_DRAIN
	} back_state_t;

	typedef struct packed {
		kind_t             kind;
		logic [IDX_W-1:0]  led;
		logic [ROW_W-1:0]  row;
		logic [CH_W-1:0]   factor;
		logic [CH_W-1:0]   fade_floor;
	} cmd_t;

endpackage

// ----- rtl/core/lsfb_ram.sv -----
module lsfb_ram #(
	parameter int WIDTH = 21,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- rtl/core/lsfb_front.sv -----
module lsfb_front
	import lsfb_pkg::*;
#(
	parameter int LED_TOTAL = 16
) (
	input  logic              start,
	input  logic              full,
	input  logic [1:0]        operation,
	input  logic [IDX_W-1:0]  pixel_index,
	input  logic [23:0]       colour_in,
	input  logic [CH_W-1:0]   fade_percent,
	input  logic [CH_W-1:0]   fade_floor,
	output logic              push,
	output cmd_t              cmd
);

	logic in_range;

	assign push     = start && !full;
	assign in_range = pixel_index < IDX_W'(LED_TOTAL);

	always_comb begin
		cmd.led        = pixel_index;
		// keep the top seven bits of each channel: green, red, blue from high to low
		cmd.row        = {colour_in[15:9], colour_in[23:17], colour_in[7:1]};
		// clamp percent to one hundred, keep the remaining share
		cmd.factor     = (fade_percent > CH_W'(FADE_DIV)) ? '0 : CH_W'(FADE_DIV) - fade_percent;
		cmd.fade_floor = fade_floor;
		unique case (operation)
			OP_SET:     cmd.kind = in_range ? K_SET : K_REJECT;
			OP_GET:     cmd.kind = in_range ? K_GET : K_REJECT;
			OP_FADE:    cmd.kind = in_range ? K_FADE : K_REJECT;
			OP_REFRESH: cmd.kind = K_REFRESH;
			default:    cmd.kind = K_REJECT;
		endcase
	end

endmodule

// ----- rtl/core/lsfb_queue.sv -----
module lsfb_queue
	import lsfb_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t cmd_in,
	output logic full,
	input  logic pop,
	output cmd_t cmd_out,
	output logic empty
);

	cmd_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full    = count_q == 2'd2;
	assign empty   = count_q == 2'd0;
	assign cmd_out = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

// ----- rtl/core/lsfb_back.sv -----
module lsfb_back
	import lsfb_pkg::*;
#(
	parameter int LED_TOTAL       = 16,
	parameter int BRIGHTNESS_FULL = 127
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             empty,
	input  cmd_t             cmd,
	output logic             pop,
	input  logic [CH_W-1:0]  brightness,
	output logic             result_valid,
	output logic [7:0]       wire_byte,
	output logic [23:0]      colour_out,
	output logic             index_rejected,
	output logic             last
);

	localparam int LED_W   = (LED_TOTAL > 1) ? $clog2(LED_TOTAL) : 1;
	localparam int CNT_MAX = 3 * LED_TOTAL + 1;
	localparam int CNT_W   = $clog2(CNT_MAX + 1);
	localparam int BF_RECIP = (1 << DIV_SHIFT) / BRIGHTNESS_FULL;

	localparam logic [RECIP_W-1:0] BF_M   = RECIP_W'(BF_RECIP);
	localparam logic [RECIP_W-1:0] FADE_M = RECIP_W'(FADE_RECIP);
	localparam logic [CH_W-1:0]    BF_D   = CH_W'(BRIGHTNESS_FULL);
	localparam logic [CH_W-1:0]    FADE_D = CH_W'(FADE_DIV);
	localparam logic [PROD_W-1:0]  CH_MAX = PROD_W'((1 << CH_W) - 1);

	function automatic logic [PROD_W-1:0] recip_quot(input logic [PROD_W-1:0] p,
			input logic [RECIP_W-1:0] m);
		logic [PROD_W+RECIP_W-1:0] prod;
		prod = (PROD_W+RECIP_W)'(p) * (PROD_W+RECIP_W)'(m);
		return PROD_W'(prod >> DIV_SHIFT);
	endfunction

	// estimate is low by at most one: add it back when the remainder reaches d
	function automatic logic [PROD_W-1:0] fix_quot(input logic [PROD_W-1:0] p,
			input logic [PROD_W-1:0] q0, input logic [CH_W-1:0] d);
		logic [PROD_W+CH_W-1:0] qd;
		logic [PROD_W+CH_W-1:0] rem;
		qd  = (PROD_W+CH_W)'(q0) * (PROD_W+CH_W)'(d);
		rem = (PROD_W+CH_W)'(p) - qd;
		return (rem >= (PROD_W+CH_W)'(d)) ? q0 + PROD_W'(1) : q0;
	endfunction

	function automatic logic [CH_W-1:0] pick(input logic [ROW_W-1:0] row, input logic [1:0] sub);
		case (sub)
			2'd0:    return row[CH_W-1:0];
			2'd1:    return row[2*CH_W-1:CH_W];
			default: return row[3*CH_W-1:2*CH_W];
		endcase
	endfunction

	back_state_t state_q, state_d;
	cmd_t        cur_q;
	logic [CNT_W-1:0] cnt_q;
	logic [LED_W-1:0] led_q;
	logic [1:0]       sub_q;
	logic [LED_TOTAL-1:0] row_valid_q;

	logic       ent_vld;
	kind_t      ent_kind;
	logic [LED_W-1:0] raddr;

	// stage 1: read data lands
	logic             vld_s1;
	kind_t            kind_s1;
	logic [1:0]       sub_s1;
	logic [LED_W-1:0] led_s1;
	logic             rowv_s1;
	logic [ROW_W-1:0] data_s1;
	logic [CH_W-1:0]  factor_s1;
	logic [CH_W-1:0]  floor_s1;
	logic [ROW_W-1:0] rdata;
	logic [ROW_W-1:0] row_rd;

	// stage 2: products
	logic              vld_s2;
	kind_t             kind_s2;
	logic [LED_W-1:0]  led_s2;
	logic [ROW_W-1:0]  row_s2;
	logic [PROD_W-1:0] pb_s2;
	logic [PROD_W-1:0] pf_s2 [3];
	logic [2:0]        nz_s2;
	logic [CH_W-1:0]   floor_s2;

	// stage 3: quotient estimates
	logic              vld_s3;
	kind_t             kind_s3;
	logic [LED_W-1:0]  led_s3;
	logic [ROW_W-1:0]  row_s3;
	logic [PROD_W-1:0] pb_s3;
	logic [PROD_W-1:0] qb_s3;
	logic [PROD_W-1:0] pf_s3 [3];
	logic [PROD_W-1:0] qf_s3 [3];
	logic [2:0]        nz_s3;
	logic [CH_W-1:0]   floor_s3;

	logic [PROD_W-1:0] qb;
	logic [CH_W-1:0]   scaled;
	logic [CH_W-1:0]   faded [3];
	logic              we;
	logic [ROW_W-1:0]  wdata;

	logic [7:0]        wire_byte_d;
	logic [23:0]       colour_d;
	logic              rejected_d;
	logic              last_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		pop      = 1'b0;
		ent_vld  = 1'b0;
		ent_kind = cur_q.kind;
		unique case (state_q)
			BS_IDLE: begin
				if (!empty) begin
					pop     = 1'b1;
					state_d = BS_ISSUE;
				end
			end
			BS_ISSUE: begin
				ent_vld = 1'b1;
				if (cur_q.kind == K_REFRESH) begin
					if (cnt_q == '0) begin
						ent_kind = K_HEAD;
					end else if (cnt_q == CNT_W'(CNT_MAX)) begin
						ent_kind = K_TAIL;
					end else begin
						ent_kind = K_BYTE;
					end
					if (cnt_q == CNT_W'(CNT_MAX)) begin
						state_d = BS_DRAIN;
					end
				end else begin
					state_d = BS_DRAIN;
				end
			end
			BS_DRAIN: begin
				// wait for the write-back so the next item reads fresh rows
				if (!(vld_s1 || vld_s2 || vld_s3)) begin
					state_d = BS_IDLE;
				end
			end
			default: state_d = BS_IDLE;
		endcase
	end

	assign raddr = (ent_kind == K_BYTE) ? led_q : cur_q.led[LED_W-1:0];

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			led_q <= '0;
			sub_q <= 2'd0;
		end else if (pop) begin
			cnt_q <= '0;
			led_q <= '0;
			sub_q <= 2'd0;
		end else if (ent_vld) begin
			cnt_q <= cnt_q + CNT_W'(1);
			if (ent_kind == K_BYTE) begin
				if (sub_q == 2'd2) begin
					sub_q <= 2'd0;
					led_q <= led_q + LED_W'(1);
				end else begin
					sub_q <= sub_q + 2'd1;
				end
			end
		end
	end

	lsfb_ram #(
		.WIDTH(ROW_W),
		.DEPTH(LED_TOTAL)
	) u_store (
		.clk  (clk),
		.we   (we),
		.waddr(led_s3),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			vld_s3      <= 1'b0;
			row_valid_q <= '0;
		end else begin
			vld_s1 <= ent_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			if (we) begin
				row_valid_q[led_s3] <= 1'b1;
			end
		end
	end

	// a row never written reads as zero
	assign row_rd = rowv_s1 ? rdata : '0;

	always_ff @(posedge clk) begin
		kind_s1   <= ent_kind;
		sub_s1    <= sub_q;
		led_s1    <= raddr;
		rowv_s1   <= row_valid_q[raddr];
		data_s1   <= cur_q.row;
		factor_s1 <= cur_q.factor;
		floor_s1  <= cur_q.fade_floor;

		kind_s2  <= kind_s1;
		led_s2   <= led_s1;
		row_s2   <= (kind_s1 == K_SET) ? data_s1 : row_rd;
		pb_s2    <= PROD_W'(pick(row_rd, sub_s1)) * PROD_W'(brightness);
		floor_s2 <= floor_s1;
		for (int i = 0; i < 3; i++) begin
			pf_s2[i] <= PROD_W'(pick(row_rd, 2'(i))) * PROD_W'(factor_s1);
			nz_s2[i] <= pick(row_rd, 2'(i)) != '0;
		end

		kind_s3  <= kind_s2;
		led_s3   <= led_s2;
		row_s3   <= row_s2;
		pb_s3    <= pb_s2;
		qb_s3    <= recip_quot(pb_s2, BF_M);
		nz_s3    <= nz_s2;
		floor_s3 <= floor_s2;
		for (int i = 0; i < 3; i++) begin
			pf_s3[i] <= pf_s2[i];
			qf_s3[i] <= recip_quot(pf_s2[i], FADE_M);
		end
	end

	always_comb begin
		qb     = fix_quot(pb_s3, qb_s3, BF_D);
		// saturate when brightness runs above full scale
		scaled = (qb > CH_MAX) ? CH_MAX[CH_W-1:0] : qb[CH_W-1:0];
		for (int i = 0; i < 3; i++) begin
			logic [PROD_W-1:0] qf;
			qf = fix_quot(pf_s3[i], qf_s3[i], FADE_D);
			faded[i] = (nz_s3[i] && (qf < PROD_W'(floor_s3))) ? floor_s3 : qf[CH_W-1:0];
		end
		we    = vld_s3 && ((kind_s3 == K_SET) || (kind_s3 == K_FADE));
		wdata = (kind_s3 == K_SET) ? row_s3 : {faded[2], faded[1], faded[0]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else begin
			result_valid <= vld_s3;
		end
	end

	always_comb begin
		wire_byte_d = 8'd0;
		colour_d    = 24'd0;
		rejected_d  = 1'b0;
		last_d      = 1'b1;
		unique case (kind_s3)
			K_HEAD:   last_d = 1'b0;
			K_BYTE: begin
				wire_byte_d = {1'b1, scaled};
				last_d      = 1'b0;
			end
			K_GET: begin
				colour_d = {row_s3[2*CH_W-1:CH_W], 1'b0, row_s3[3*CH_W-1:2*CH_W], 1'b0,
					row_s3[CH_W-1:0], 1'b0};
			end
			K_REJECT: rejected_d = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		wire_byte      <= wire_byte_d;
		colour_out     <= colour_d;
		index_rejected <= rejected_d;
		last           <= last_d;
	end

endmodule

// ----- rtl/core/led_strip_frame_buffer_top.sv -----
// LED strip frame buffer. Holds a 7-bit blue, red and green value per LED and takes
// one command per start pulse (accepted when start is high and busy is low): set
// stores the top seven bits of each channel of colour_in, get returns the stored
// triple rebuilt as a 24-bit colour, fade scales the three channels of one LED by
// (100 - fade_percent) / 100 with a floor for nonzero channels, and refresh streams
// the frame as wire bytes: a zero byte, every stored channel scaled by
// brightness / BRIGHTNESS_FULL with bit 7 set, then a closing zero byte. For set,
// get and fade, a pixel index at or above LED_TOTAL leaves the store alone and
// comes back with index_rejected set. Results are shown for exactly one cycle under
// result_valid, and last marks the final result of each command; there is no way to
// hold them off, so the receiver must take every result as it comes. Set, get and
// fade each give a single result, which passes the queue, the command register, the
// pipeline and the output registers; a refresh delivers 3 * LED_TOTAL + 2 results on
// consecutive cycles. The back end works through one command at a time over a
// four-stage pipeline (store read, multiply, reciprocal estimate, correction) and
// drains it before the next command so a fade's write-back is seen by what follows.
// A two-entry command queue sits in front, so up to two more commands are taken
// while one runs; busy is high while that queue is full. The store needs no clearing
// pass after reset: a valid bit per LED makes unwritten rows read as zero. brightness
// resets to BRIGHTNESS_FULL and is written through cfg_valid / cfg_ready / cfg_data;
// write it only while no command is outstanding.
module led_strip_frame_buffer_top
	import lsfb_pkg::*;
#(
	parameter int LED_TOTAL       = 16,
	parameter int BRIGHTNESS_FULL = 127
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [1:0]        operation,
	input  logic [IDX_W-1:0]  pixel_index,
	input  logic [23:0]       colour_in,
	input  logic [CH_W-1:0]   fade_percent,
	input  logic [CH_W-1:0]   fade_floor,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CH_W-1:0]   cfg_data,
	output logic              result_valid,
	output logic [7:0]        wire_byte,
	output logic [23:0]       colour_out,
	output logic              index_rejected,
	output logic              last
);

	logic            push;
	logic            full;
	logic            empty;
	logic            pop;
	cmd_t            cmd_in;
	cmd_t            cmd_out;
	logic [CH_W-1:0] brightness_q;

	// the user must write brightness only while idle; the block does not enforce it, so take every write at once
	assign cfg_ready = 1'b1;
	assign busy      = full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			brightness_q <= CH_W'(BRIGHTNESS_FULL);
		end else if (cfg_valid && cfg_ready) begin
			brightness_q <= cfg_data;
		end
	end

	// classify the command and check the index
	lsfb_front #(
		.LED_TOTAL(LED_TOTAL)
	) u_front (
		.start       (start),
		.full        (full),
		.operation   (operation),
		.pixel_index (pixel_index),
		.colour_in   (colour_in),
		.fade_percent(fade_percent),
		.fade_floor  (fade_floor),
		.push        (push),
		.cmd         (cmd_in)
	);

	// decouple intake from execution
	lsfb_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.cmd_in (cmd_in),
		.full   (full),
		.pop    (pop),
		.cmd_out(cmd_out),
		.empty  (empty)
	);

	// execute against the frame store and drive the result ports
	lsfb_back #(
		.LED_TOTAL      (LED_TOTAL),
		.BRIGHTNESS_FULL(BRIGHTNESS_FULL)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.empty         (empty),
		.cmd           (cmd_out),
		.pop           (pop),
		.brightness    (brightness_q),
		.result_valid  (result_valid),
		.wire_byte     (wire_byte),
		.colour_out    (colour_out),
		.index_rejected(index_rejected),
		.last          (last)
	);

endmodule

// ----- rtl/core/lsfb_checker.sv -----
module lsfb_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        result_valid,
	input logic [7:0]  wire_byte,
	input logic [23:0] colour_out,
	input logic        index_rejected,
	input logic        last
);

	// a rejected index gives a lone, empty result
	a_reject_alone: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && index_rejected |-> last && (wire_byte == 8'd0) && (colour_out == 24'd0))
		else $error("rejected result carries data or is not last");

	// wire bytes always have the start bit and never close an item
	a_byte_marked: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (wire_byte != 8'd0) |-> wire_byte[7] && !last && (colour_out == 24'd0)
			&& !index_rejected)
		else $error("malformed wire byte");

	// a read-back colour is the single result of a get
	a_colour_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (colour_out != 24'd0) |-> last && !index_rejected)
		else $error("colour on a non-final result");

	// the refresh stream runs without gaps until its closing byte
	a_stream_gapless: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && wire_byte[7] |=> result_valid)
		else $error("gap in refresh stream");

endmodule

bind led_strip_frame_buffer_top lsfb_checker u_lsfb_checker (.*);

// ----- bench/tb_led_strip_frame_buffer_top.sv -----
module tb_led_strip_frame_buffer_top
	import lsfb_pkg::*;
();

	localparam int LED_TOTAL       = 16;
	localparam int BRIGHTNESS_FULL = 127;
	localparam int STORE_DEPTH     = LED_TOTAL * 3;
	localparam int PCT_FULL        = 100;
	localparam int QUIET_LIMIT     = 4000;  // cycles with no handshake of any kind
	localparam int SETTLE_CYCLES   = 20;    // idle tail after the last result

	// One result as the strip side sees it.
	typedef struct packed {
		logic [7:0]  wire_byte;
		logic [23:0] colour;
		logic        rejected;
		logic        last;
	} strip_result_t;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic [1:0]        operation;
	logic [IDX_W-1:0]  pixel_index;
	logic [23:0]       colour_in;
	logic [CH_W-1:0]   fade_percent;
	logic [CH_W-1:0]   fade_floor;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [CH_W-1:0]   cfg_data;
	logic              result_valid;
	logic [7:0]        wire_byte;
	logic [23:0]       colour_out;
	logic              index_rejected;
	logic              last;

	// Shadow of the LED store and the brightness register.
	logic [CH_W-1:0]   shadow_store [STORE_DEPTH];
	logic [CH_W-1:0]   shadow_brightness;

	strip_result_t     pending_results [$];
	int                error_count;
	int                quiet_cycles;
	int                gap_pct;

	led_strip_frame_buffer_top #(
		.LED_TOTAL       (LED_TOTAL),
		.BRIGHTNESS_FULL (BRIGHTNESS_FULL)
	) u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.operation      (operation),
		.pixel_index    (pixel_index),
		.colour_in      (colour_in),
		.fade_percent   (fade_percent),
		.fade_floor     (fade_floor),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.result_valid   (result_valid),
		.wire_byte      (wire_byte),
		.colour_out     (colour_out),
		.index_rejected (index_rejected),
		.last           (last)
	);

	always #5 clk = ~clk;

	// Scale one channel down by a percentage; a lit channel never drops below the floor.
	function automatic logic [CH_W-1:0] faded_level(logic [CH_W-1:0] level, int pct,
			logic [CH_W-1:0] flr);
		int nv;
		nv = (int'(level) * (PCT_FULL - pct)) / PCT_FULL;
		if (nv < int'(flr) && level != '0)
			nv = int'(flr);
		return nv[CH_W-1:0];
	endfunction

	// Apply one accepted command to the shadow store and queue the results it yields.
	function automatic void predict_strip_command(logic [1:0] op, logic [IDX_W-1:0] idx,
			logic [23:0] col, logic [CH_W-1:0] pct, logic [CH_W-1:0] flr);
		strip_result_t r;
		int            base;
		int            scaled;
		int            eff_pct;
		r = '0;
		if (op == OP_REFRESH) begin
			// Open with a zero byte, stream every channel with bit 7 set, close with zero.
			pending_results.push_back(r);
			for (int i = 0; i < STORE_DEPTH; i++) begin
				scaled = (int'(shadow_store[i]) * int'(shadow_brightness)) / BRIGHTNESS_FULL;
				if (scaled > 127)
					scaled = 127;
				r.wire_byte = 8'h80 | scaled[7:0];
				pending_results.push_back(r);
			end
			r.wire_byte = '0;
			r.last = 1'b1;
			pending_results.push_back(r);
			return;
		end
		r.last = 1'b1;
		if (int'(idx) >= LED_TOTAL) begin
			// Out of range: leave the store alone and flag it.
			r.rejected = 1'b1;
			pending_results.push_back(r);
			return;
		end
		base = int'(idx) * 3;
		case (op)
			OP_SET: begin
				shadow_store[base]     = col[7:1];
				shadow_store[base + 1] = col[23:17];
				shadow_store[base + 2] = col[15:9];
			end
			OP_GET: begin
				r.colour = {shadow_store[base + 1], 1'b0, shadow_store[base + 2], 1'b0,
					shadow_store[base], 1'b0};
			end
			default: begin
				// Anything above a hundred percent fades fully.
				eff_pct = (int'(pct) > PCT_FULL) ? PCT_FULL : int'(pct);
				for (int c = 0; c < 3; c++)
					shadow_store[base + c] = faded_level(shadow_store[base + c], eff_pct, flr);
			end
		endcase
		pending_results.push_back(r);
	endfunction

	// Drive one command at the falling edge, hold it until taken, then predict it.
	task automatic send_strip_command(logic [1:0] op, logic [IDX_W-1:0] idx, logic [23:0] col,
			logic [CH_W-1:0] pct, logic [CH_W-1:0] flr);
		@(negedge clk);
		while ($urandom_range(99) < gap_pct) begin
			start = 1'b0;
			@(negedge clk);
		end
		start        = 1'b1;
		operation    = op;
		pixel_index  = idx;
		colour_in    = col;
		fade_percent = pct;
		fade_floor   = flr;
		// busy only moves at the rising edge, so its value now holds for the coming edge
		while (busy)
			@(negedge clk);
		@(posedge clk);
		predict_strip_command(op, idx, col, pct, flr);
	endtask

	// Drop start and wait until every queued result has come back.
	task automatic drain_results();
		@(negedge clk);
		start = 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// Write brightness only once the block has nothing outstanding.
	task automatic write_brightness(logic [CH_W-1:0] level);
		drain_results();
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_data  = level;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		shadow_brightness = level;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic report_mismatch(string field, logic [23:0] want, logic [23:0] got);
		$display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
		error_count++;
	endtask

	// Check each strobed result against the oldest expectation.
	always @(posedge clk) begin
		strip_result_t want;
		if (arst_n && result_valid) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual byte %h colour %h",
					$time, wire_byte, colour_out);
				error_count++;
			end else begin
				want = pending_results.pop_front();
				if (wire_byte !== want.wire_byte)
					report_mismatch("wire_byte", 24'(want.wire_byte), 24'(wire_byte));
				if (colour_out !== want.colour)
					report_mismatch("colour_out", want.colour, colour_out);
				if (index_rejected !== want.rejected)
					report_mismatch("index_rejected", 24'(want.rejected), 24'(index_rejected));
				if (last !== want.last)
					report_mismatch("last", 24'(want.last), 24'(last));
			end
		end
	end

	// End the run if nothing moves on any port for too long.
	always @(posedge clk) begin
		if ((start && !busy) || result_valid || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
			$display("led_strip_frame_buffer_top verification failed");
			$finish;
		end
	end

	// Extremes of every field and every special case, on a known frame.
	task automatic test_directed_commands();
		gap_pct = 34;
		send_strip_command(OP_REFRESH, 8'd0, 24'h0, 7'd0, 7'd0);      // all-dark frame
		send_strip_command(OP_SET, 8'd0, 24'hFFFFFF, 7'd0, 7'd0);
		send_strip_command(OP_SET, 8'd15, 24'h80_01_FE, 7'd0, 7'd0);
		send_strip_command(OP_SET, 8'd1, 24'hAA_55_C3, 7'd0, 7'd0);
		send_strip_command(OP_SET, 8'd3, 24'h000000, 7'd127, 7'd127);
		send_strip_command(OP_GET, 8'd0, 24'h0, 7'd0, 7'd0);
		send_strip_command(OP_GET, 8'd15, 24'hFFFFFF, 7'd127, 7'd127);
		send_strip_command(OP_GET, 8'd2, 24'h0, 7'd0, 7'd0);          // never written
		send_strip_command(OP_SET, 8'd16, 24'h123456, 7'd0, 7'd0);    // first rejected index
		send_strip_command(OP_GET, 8'd255, 24'h0, 7'd0, 7'd0);
		send_strip_command(OP_FADE, 8'd200, 24'h0, 7'd50, 7'd0);
		send_strip_command(OP_FADE, 8'd0, 24'h0, 7'd0, 7'd0);         // no change
		send_strip_command(OP_FADE, 8'd0, 24'h0, 7'd50, 7'd0);
		send_strip_command(OP_FADE, 8'd0, 24'h0, 7'd127, 7'd10);      // clamp, then floor
		send_strip_command(OP_FADE, 8'd15, 24'h0, 7'd100, 7'd0);      // fade to black
		send_strip_command(OP_FADE, 8'd1, 24'h0, 7'd99, 7'd127);      // floor above value
		send_strip_command(OP_FADE, 8'd2, 24'h0, 7'd10, 7'd127);      // dark stays dark
		send_strip_command(OP_GET, 8'd0, 24'h0, 7'd0, 7'd0);
		send_strip_command(OP_GET, 8'd1, 24'h0, 7'd0, 7'd0);
		send_strip_command(OP_REFRESH, 8'd255, 24'hFFFFFF, 7'd127, 7'd127);
	endtask

	// Refresh the same frame at brightness zero, one and one midpoint.
	task automatic test_brightness_levels();
		gap_pct = 0;
		write_brightness(7'd0);
		send_strip_command(OP_REFRESH, 8'd0, 24'h0, 7'd0, 7'd0);
		write_brightness(7'd1);
		send_strip_command(OP_REFRESH, 8'd0, 24'h0, 7'd0, 7'd0);
		write_brightness(7'd64);
		send_strip_command(OP_REFRESH, 8'd0, 24'h0, 7'd0, 7'd0);
	endtask

	// Random mix, mostly in-range pixels so fades act on lit LEDs.
	task automatic test_random_traffic(int count, int gap, logic [CH_W-1:0] level);
		int               pick;
		logic [1:0]       op;
		logic [IDX_W-1:0] idx;
		logic [CH_W-1:0]  flr;
		write_brightness(level);
		gap_pct = gap;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(99);
			if (pick < 30)
				op = OP_SET;
			else if (pick < 55)
				op = OP_GET;
			else if (pick < 88)
				op = OP_FADE;
			else
				op = OP_REFRESH;
			if ($urandom_range(9) == 0)
				idx = IDX_W'($urandom_range(255, LED_TOTAL));
			else
				idx = IDX_W'($urandom_range(LED_TOTAL - 1));
			flr = $urandom_range(1) ? CH_W'($urandom_range(15)) : CH_W'($urandom_range(127));
			send_strip_command(op, idx, 24'($urandom_range(24'hFFFFFF)),
				CH_W'($urandom_range(127)), flr);
		end
	endtask

	initial begin
		clk               = 1'b0;
		arst_n            = 1'b0;
		start             = 1'b0;
		operation         = OP_SET;
		pixel_index       = '0;
		colour_in         = '0;
		fade_percent      = '0;
		fade_floor        = '0;
		cfg_valid         = 1'b0;
		cfg_data          = '0;
		error_count       = 0;
		quiet_cycles      = 0;
		gap_pct           = 0;
		shadow_brightness = CH_W'(BRIGHTNESS_FULL);
		for (int i = 0; i < STORE_DEPTH; i++)
			shadow_store[i] = '0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		test_directed_commands();
		test_brightness_levels();
		test_random_traffic(150, 34, CH_W'($urandom_range(126, 1)));
		test_random_traffic(150, 67, CH_W'($urandom_range(126, 1)));
		test_random_traffic(150, 0, 7'd127);

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending_results.size() != 0) begin
			$display("%0t: %0d results never arrived", $time, pending_results.size());
			error_count++;
		end
		if (error_count == 0) begin
			$display("led_strip_frame_buffer_top verification clean");
		end else begin
			$display("led_strip_frame_buffer_top verification failed");
		end
		$finish;
	end

endmodule
